### rtl/assert_macros.svh
// Assertion helpers. Both expect clk in scope; LIF_ASSERT also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check while out of reset.
`define LIF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every edge, reset included.
`define LIF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/lifds_pkg.sv
package lifds_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int CNT_W       = $clog2(WINDOW_MAX + 1);
  localparam int GRP_SIZE    = 8;
  localparam int NUM_GRP     = (WINDOW_MAX + GRP_SIZE - 1) / GRP_SIZE;
  localparam int GRP_W       = $clog2(GRP_SIZE + 1);
  localparam int CMP_W       = (CNT_W > 7) ? CNT_W : 7;

  localparam int Q16_W       = 16;
  localparam int ANGLE_W     = 16;
  localparam int WLEN_W      = 7;
  localparam int DCNT_W      = 7;
  localparam int COUNT_OUT_W = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int EXT_W       = ANGLE_W + 2;
  localparam int DELTA_W     = 15;
  localparam int GAIN_W      = 13;
  localparam int PROD_W      = DELTA_W + GAIN_W;
  localparam int SUM_W       = PROD_W + 2;
  localparam int RND_W       = SUM_W - 7;
  localparam int EYE_TERM_W  = 18;
  localparam int TOTAL_W     = RND_W + 1;
  localparam int CURRENT_W   = 21;
  localparam int V_W         = CURRENT_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DROWSY_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAK_FACTOR   = 2'd2;

  localparam logic [WLEN_W-1:0] WLEN_RESET      = 7'd45;
  localparam logic [WLEN_W-1:0] WINDOW_FALLBACK = 7'd45;
  localparam logic [DCNT_W-1:0] DCNT_RESET      = 7'd10;
  localparam logic [Q16_W-1:0]  LEAK_RESET      = 16'd55706;

  localparam logic [Q16_W-1:0]        EYE_LIMIT       = 16'd13763;
  localparam logic [EYE_TERM_W-1:0]   EYE_GAIN        = 18'd18;
  localparam logic signed [EXT_W-1:0] PITCH_DOWN_EDGE = -18'sd1536;
  localparam logic signed [EXT_W-1:0] PITCH_UP_EDGE   = 18'sd2560;
  localparam logic signed [EXT_W-1:0] YAW_EDGE        = 18'sd2560;
  localparam logic signed [EXT_W-1:0] ROLL_EDGE       = 18'sd2304;
  localparam logic [PROD_W-1:0]       GAIN_DOWN       = 28'd5243;
  localparam logic [PROD_W-1:0]       GAIN_UP         = 28'd3277;
  localparam logic [PROD_W-1:0]       GAIN_SIDE       = 28'd2621;
  localparam logic [SUM_W-1:0]        ANGLE_HALF      = 30'd64;
  localparam logic [TOTAL_W-1:0]      CURRENT_MAX     = 24'd2097151;

  typedef struct packed {
    logic                      action;
    logic [Q16_W-1:0]          eye_ratio;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] yaw_angle;
    logic signed [ANGLE_W-1:0] roll_angle;
  } frame_t;

  typedef struct packed {
    logic                  clear;
    logic [EYE_TERM_W-1:0] eye_term;
    logic [PROD_W-1:0]     down_term;
    logic [PROD_W-1:0]     up_term;
    logic [PROD_W-1:0]     yaw_term;
    logic [PROD_W-1:0]     roll_term;
  } prod_t;

  typedef struct packed {
    logic                 clear;
    logic [CURRENT_W-1:0] current;
  } drive_t;

  typedef struct packed {
    logic                  spike;
    logic [Q16_W-1:0]      potential;
    logic [WINDOW_MAX-1:0] history;
  } fire_t;

endpackage

### rtl/lifds_in_if.sv
interface lifds_in_if;
  import lifds_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [Q16_W-1:0]          eye_ratio;
  logic signed [ANGLE_W-1:0] pitch_angle;
  logic signed [ANGLE_W-1:0] yaw_angle;
  logic signed [ANGLE_W-1:0] roll_angle;

  modport source (output valid, action, eye_ratio, pitch_angle, yaw_angle, roll_angle,
                  input ready);
  modport sink (input valid, action, eye_ratio, pitch_angle, yaw_angle, roll_angle,
                output ready);
endinterface

### rtl/lifds_out_if.sv
interface lifds_out_if;
  import lifds_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   spike;
  logic [COUNT_OUT_W-1:0] spike_count;
  logic                   drowsy;
  logic [Q16_W-1:0]       potential;

  modport source (output valid, spike, spike_count, drowsy, potential, input ready);
  modport sink (input valid, spike, spike_count, drowsy, potential, output ready);
endinterface

### rtl/lifds_cfg_if.sv
interface lifds_cfg_if;
  import lifds_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

### rtl/lifds_current.sv
module lifds_current (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lifds_pkg::frame_t in_frame,
  output logic              out_valid,
  input  logic              out_ready,
  output lifds_pkg::drive_t out_drive
);
  import lifds_pkg::*;

  logic                     prod_valid_r;
  prod_t                    prod_r;
  prod_t                    prod_nxt;
  logic                     prod_ready;
  logic                     drive_valid_r;
  drive_t                   drive_r;
  drive_t                   drive_nxt;
  logic                     drive_ready;

  logic signed [EXT_W-1:0]  pitch_x;
  logic signed [EXT_W-1:0]  yaw_x;
  logic signed [EXT_W-1:0]  roll_x;
  logic signed [EXT_W-1:0]  yaw_mag;
  logic signed [EXT_W-1:0]  roll_mag;
  logic signed [EXT_W-1:0]  d_down;
  logic signed [EXT_W-1:0]  d_up;
  logic signed [EXT_W-1:0]  d_yaw;
  logic signed [EXT_W-1:0]  d_roll;
  logic [SUM_W-1:0]         angle_sum;
  logic [RND_W-1:0]         angle_rnd;
  logic [TOTAL_W-1:0]       total;

  assign drive_ready = !drive_valid_r || out_ready;
  assign prod_ready  = !prod_valid_r || drive_ready;
  assign in_ready    = prod_ready;

  always_comb begin
    pitch_x  = EXT_W'(in_frame.pitch_angle);
    yaw_x    = EXT_W'(in_frame.yaw_angle);
    roll_x   = EXT_W'(in_frame.roll_angle);
    yaw_mag  = yaw_x[EXT_W-1] ? -yaw_x : yaw_x;
    roll_mag = roll_x[EXT_W-1] ? -roll_x : roll_x;
    d_down   = PITCH_DOWN_EDGE - pitch_x;
    d_up     = pitch_x - PITCH_UP_EDGE;
    d_yaw    = yaw_mag - YAW_EDGE;
    d_roll   = roll_mag - ROLL_EDGE;

    prod_nxt.clear     = in_frame.action;
    prod_nxt.eye_term  = (in_frame.eye_ratio < EYE_LIMIT)
                       ? EYE_TERM_W'(EYE_LIMIT - in_frame.eye_ratio) * EYE_GAIN : '0;
    prod_nxt.down_term = (pitch_x < PITCH_DOWN_EDGE)
                       ? PROD_W'(d_down[DELTA_W-1:0]) * GAIN_DOWN : '0;
    prod_nxt.up_term   = (pitch_x > PITCH_UP_EDGE)
                       ? PROD_W'(d_up[DELTA_W-1:0]) * GAIN_UP : '0;
    prod_nxt.yaw_term  = (yaw_mag > YAW_EDGE)
                       ? PROD_W'(d_yaw[DELTA_W-1:0]) * GAIN_SIDE : '0;
    prod_nxt.roll_term = (roll_mag > ROLL_EDGE)
                       ? PROD_W'(d_roll[DELTA_W-1:0]) * GAIN_SIDE : '0;
  end

  always_comb begin
    angle_sum = SUM_W'(prod_r.down_term) + SUM_W'(prod_r.up_term)
              + SUM_W'(prod_r.yaw_term) + SUM_W'(prod_r.roll_term);
    angle_rnd = RND_W'((angle_sum + ANGLE_HALF) >> 7);
    total     = TOTAL_W'(angle_rnd) + TOTAL_W'(prod_r.eye_term);
    drive_nxt.clear   = prod_r.clear;
    drive_nxt.current = (total > CURRENT_MAX) ? CURRENT_MAX[CURRENT_W-1:0]
                                              : total[CURRENT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r  <= 1'b0;
      drive_valid_r <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_valid_r <= in_valid;
      end
      if (drive_ready) begin
        drive_valid_r <= prod_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && in_valid) begin
      prod_r <= prod_nxt;
    end
    if (drive_ready && prod_valid_r) begin
      drive_r <= drive_nxt;
    end
  end

  assign out_valid = drive_valid_r;
  assign out_drive = drive_r;

endmodule

### rtl/lifds_neuron.sv
module lifds_neuron (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lifds_pkg::Q16_W-1:0] leak_factor,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  lifds_pkg::drive_t           in_drive,
  output logic                        out_valid,
  input  logic                        out_ready,
  output lifds_pkg::fire_t            out_fire
);
  import lifds_pkg::*;

  logic [Q16_W-1:0]      membrane_r;
  logic [Q16_W-1:0]      membrane_nxt;
  logic [WINDOW_MAX-1:0] history_r;
  logic [WINDOW_MAX-1:0] history_nxt;
  logic                  fire_valid_r;
  fire_t                 fire_r;
  logic                  spike;
  logic                  take;
  logic [2*Q16_W-1:0]    leak_prod;
  logic [Q16_W:0]        leaked;
  logic [V_W-1:0]        v_sum;

  assign in_ready = !fire_valid_r || out_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    leak_prod = (2*Q16_W)'(membrane_r) * (2*Q16_W)'(leak_factor);
    leaked    = (Q16_W+1)'(((2*Q16_W+1)'(leak_prod) + (2*Q16_W+1)'(32768)) >> Q16_W);
    v_sum     = V_W'(leaked) + V_W'(in_drive.current);
    spike     = 1'b0;
    if (in_drive.clear) begin
      membrane_nxt = '0;
      history_nxt  = '0;
    end else begin
      spike        = |v_sum[V_W-1:Q16_W];
      membrane_nxt = spike ? '0 : v_sum[Q16_W-1:0];
      history_nxt  = {history_r[WINDOW_MAX-2:0], spike};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      membrane_r   <= '0;
      history_r    <= '0;
      fire_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        fire_valid_r <= in_valid;
      end
      if (take) begin
        membrane_r <= membrane_nxt;
        history_r  <= history_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fire_r.spike     <= spike;
      fire_r.potential <= membrane_nxt;
      fire_r.history   <= history_nxt;
    end
  end

  assign out_valid = fire_valid_r;
  assign out_fire  = fire_r;

endmodule

### rtl/lifds_window.sv
module lifds_window (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [lifds_pkg::CNT_W-1:0]       win_n,
  input  logic [lifds_pkg::DCNT_W-1:0]      drowsy_count,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lifds_pkg::fire_t                  in_fire,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_fire_bit,
  output logic [lifds_pkg::COUNT_OUT_W-1:0] out_count,
  output logic                              out_drowsy,
  output logic [lifds_pkg::Q16_W-1:0]       out_potential
);
  import lifds_pkg::*;

  logic [WINDOW_MAX-1:0]            mask;
  logic [WINDOW_MAX-1:0]            live;
  logic [NUM_GRP-1:0][GRP_W-1:0]    part_nxt;
  logic [NUM_GRP-1:0][GRP_W-1:0]    part_r;
  logic                             part_valid_r;
  logic                             part_spike_r;
  logic [Q16_W-1:0]                 part_pot_r;
  logic                             part_ready;
  logic [CNT_W-1:0]                 count;
  logic                             res_valid_r;
  logic                             res_ready;
  logic                             res_spike_r;
  logic [COUNT_OUT_W-1:0]           res_count_r;
  logic                             res_drowsy_r;
  logic [Q16_W-1:0]                 res_pot_r;

  assign res_ready  = !res_valid_r || out_ready;
  assign part_ready = !part_valid_r || res_ready;
  assign in_ready   = part_ready;

  always_comb begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      mask[i] = (32'(i) < 32'(win_n));
    end
    live = in_fire.history & mask;
    for (int g = 0; g < NUM_GRP; g++) begin
      part_nxt[g] = '0;
      for (int j = 0; j < GRP_SIZE; j++) begin
        if (g * GRP_SIZE + j < WINDOW_MAX) begin
          part_nxt[g] = part_nxt[g] + GRP_W'(live[g * GRP_SIZE + j]);
        end
      end
    end
  end

  always_comb begin
    count = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      count = count + CNT_W'(part_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      if (part_ready) begin
        part_valid_r <= in_valid;
      end
      if (res_ready) begin
        res_valid_r <= part_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (part_ready && in_valid) begin
      part_r       <= part_nxt;
      part_spike_r <= in_fire.spike;
      part_pot_r   <= in_fire.potential;
    end
    if (res_ready && part_valid_r) begin
      res_spike_r  <= part_spike_r;
      res_count_r  <= COUNT_OUT_W'(count);
      res_drowsy_r <= (CMP_W'(count) >= CMP_W'(drowsy_count));
      res_pot_r    <= part_pot_r;
    end
  end

  assign out_valid     = res_valid_r;
  assign out_fire_bit  = res_spike_r;
  assign out_count     = res_count_r;
  assign out_drowsy    = res_drowsy_r;
  assign out_potential = res_pot_r;

endmodule

### rtl/lif_drowsiness_spike_window_core.sv
// Channel   Dir  Payload                                           Role
// in_chan   in   action, eye_ratio, pitch/yaw/roll_angle           one video frame or clear
// out_chan  out  spike, spike_count, drowsy, potential             one beat per input beat
// cfg_chan  in   index, wdata                                      window_length, drowsy_count,
//                                                                  leak_factor
//
// One beat in every cycle unless out_chan stalls; registers s1, prod, drive, fire, part, res.
// Rate is set by the membrane update (leak multiply, add, fire compare), all combinational.
// rst_n is synchronous: pipeline empties, membrane and spike history clear, registers reload.
// Every stage holds its beat while the next one is full; bubbles still close up under a stall.
`include "assert_macros.svh"

module lif_drowsiness_spike_window_core (
  input  logic        clk,
  input  logic        rst_n,
  lifds_in_if.sink    in_chan,
  lifds_out_if.source out_chan,
  lifds_cfg_if.sink   cfg_chan
);
  import lifds_pkg::*;

  logic [WLEN_W-1:0] wlen_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [Q16_W-1:0]  leak_r;
  logic [WLEN_W-1:0] wlen_pick;
  logic [CNT_W-1:0]  win_n;

  logic              s1_valid_r;
  frame_t            s1_frame_r;
  logic              s1_ready;

  logic              drv_valid;
  logic              drv_ready;
  drive_t            drv;
  logic              fire_valid;
  logic              fire_ready;
  fire_t             fire;

  logic [CMP_W-1:0]  out_cnt_x;
  logic [CMP_W-1:0]  win_x;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= WLEN_RESET;
      dcnt_r <= DCNT_RESET;
      leak_r <= LEAK_RESET;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_WINDOW_LENGTH: wlen_r <= cfg_chan.wdata[WLEN_W-1:0];
        CFG_DROWSY_COUNT:  dcnt_r <= cfg_chan.wdata[DCNT_W-1:0];
        CFG_LEAK_FACTOR:   leak_r <= cfg_chan.wdata[Q16_W-1:0];
        default: ;
      endcase
    end
  end

  assign wlen_pick = (wlen_r == '0) ? WINDOW_FALLBACK : wlen_r;
  assign win_n     = (32'(wlen_pick) > 32'(WINDOW_MAX)) ? CNT_W'(WINDOW_MAX)
                                                        : CNT_W'(wlen_pick);

  assign in_chan.ready = !s1_valid_r || s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_frame_r.action      <= in_chan.action;
      s1_frame_r.eye_ratio   <= in_chan.eye_ratio;
      s1_frame_r.pitch_angle <= in_chan.pitch_angle;
      s1_frame_r.yaw_angle   <= in_chan.yaw_angle;
      s1_frame_r.roll_angle  <= in_chan.roll_angle;
    end
  end

  lifds_current u_current (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid_r),
    .in_ready  (s1_ready),
    .in_frame  (s1_frame_r),
    .out_valid (drv_valid),
    .out_ready (drv_ready),
    .out_drive (drv)
  );

  lifds_neuron u_neuron (
    .clk         (clk),
    .rst_n       (rst_n),
    .leak_factor (leak_r),
    .in_valid    (drv_valid),
    .in_ready    (drv_ready),
    .in_drive    (drv),
    .out_valid   (fire_valid),
    .out_ready   (fire_ready),
    .out_fire    (fire)
  );

  lifds_window u_window (
    .clk           (clk),
    .rst_n         (rst_n),
    .win_n         (win_n),
    .drowsy_count  (dcnt_r),
    .in_valid      (fire_valid),
    .in_ready      (fire_ready),
    .in_fire       (fire),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .out_fire_bit  (out_chan.spike),
    .out_count     (out_chan.spike_count),
    .out_drowsy    (out_chan.drowsy),
    .out_potential (out_chan.potential)
  );

  assign out_cnt_x = CMP_W'(out_chan.spike_count);
  assign win_x     = CMP_W'(win_n);

  `LIF_ASSERT(a_spike_zero, out_chan.spike |-> out_chan.potential == '0, "spike kept potential")
  `LIF_ASSERT(a_count_le_win, out_chan.valid |-> out_cnt_x <= win_x, "count above window")
  `LIF_ASSERT_ALWAYS(a_reset_flush, !rst_n |=> !out_chan.valid && !s1_valid_r, "not flushed")

endmodule
